FILE: rtl/integer_to_ascii_formatter_unit_defines.svh
// Assertion shorthands used by the checker file of this block.
// Every property is clocked on i_clk and is off while i_rst_n is low.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/itaf_pkg.sv
package itaf_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int DEF_MAX_FIELD   = 31;
    localparam int DEF_DIGIT_LIMIT = 20;
    localparam int MAX_OUT         = 32;

    // Digit counts that a full-width magnitude can need in octal and in decimal.
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NUM_DIG    = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value_bits;
        logic [1:0]             radix_select;
        logic [4:0]             min_width;
        logic [4:0]             precision;
        logic                   left_justify;
        logic                   force_plus;
        logic                   space_sign;
        logic                   zero_pad;
        logic                   uppercase;
        logic                   unsigned_mode;
    } t_fmt_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_fmt_out;

    typedef struct packed {
        logic load;
        logic convert;
        logic measure;
        logic size;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic emit_last;
    } t_dp_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

FILE: rtl/itaf_ctrl.sv
module itaf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  itaf_pkg::t_dp_status i_status,
    output itaf_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);
    import itaf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_MEASURE,
        ST_SIZE,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (i_status.conv_done) n_state = ST_MEASURE;
            end
            ST_MEASURE: begin
                n_state = ST_SIZE;
            end
            ST_SIZE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.emit_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_comb begin
        o_cmd.load    = (r_state == ST_IDLE) && i_start;
        o_cmd.convert = (r_state == ST_CONVERT);
        o_cmd.measure = (r_state == ST_MEASURE);
        o_cmd.size    = (r_state == ST_SIZE);
        o_cmd.emit    = (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/itaf_datapath.sv
module itaf_datapath #(
    parameter int MAX_FIELD   = itaf_pkg::DEF_MAX_FIELD,
    parameter int DIGIT_LIMIT = itaf_pkg::DEF_DIGIT_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itaf_pkg::t_fmt_in    i_item,
    input  itaf_pkg::t_dp_cmd    i_cmd,
    output itaf_pkg::t_dp_status o_status,
    output itaf_pkg::t_fmt_out   o_result,
    output logic                 o_valid
);
    import itaf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELD + DIGIT_LIMIT + 34);
    localparam int ND_W  = $clog2(NUM_DIG + 1);
    localparam int IDX_W = $clog2(NUM_DIG);
    localparam int EXT_W = NUM_DIG * 4;
    localparam int BIT_W = $clog2(VALUE_WIDTH);

    // Item context captured when the transaction is accepted.
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [1:0]             r_radix;
    logic                   r_is_dec;
    logic [CNT_W-1:0]       r_width;
    logic [CNT_W-1:0]       r_prec;
    logic                   r_left;
    logic                   r_zpad;
    logic                   r_upper;
    logic                   r_has_sign;
    logic [7:0]             r_sign_ch;

    // Digit lanes, least significant digit at index zero.
    logic [3:0]             r_digits [NUM_DIG];
    logic [BIT_W-1:0]       r_bit_cnt;
    logic [ND_W-1:0]        r_nd;

    // Output sequencing counters.
    logic [CNT_W-1:0]       r_pad_cnt;
    logic [CNT_W-1:0]       r_zero_cnt;
    logic [ND_W-1:0]        r_dig_left;
    logic                   r_sign_pend;
    logic [CNT_W-1:0]       r_remain;
    logic [CNT_W-1:0]       r_emit_cnt;

    t_fmt_out               r_out;
    logic                   r_valid;

    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [CNT_W-1:0]       width_in;
    logic [CNT_W-1:0]       prec_in;
    logic [7:0]             sign_in;

    logic [3:0]             adj    [NUM_DIG];
    logic [3:0]             dd_nxt [NUM_DIG];
    logic [3:0]             oct_d  [NUM_DIG];
    logic [3:0]             hex_d  [NUM_DIG];
    logic [EXT_W-1:0]       mag_ext;

    logic [ND_W-1:0]        sig_cnt;
    logic [ND_W-1:0]        nd_cap;

    logic [CNT_W-1:0]       nd_ext;
    logic [CNT_W-1:0]       sz_zeros;
    logic [CNT_W-1:0]       sz_body;
    logic [CNT_W-1:0]       sz_pad;
    logic [CNT_W-1:0]       sz_total;

    logic [ND_W-1:0]        dig_dec;
    logic [IDX_W-1:0]       dig_idx;
    logic                   take_lead;
    logic                   take_trail;
    logic [7:0]             emit_ch;
    logic                   emit_last;

    // Accept-time decode: sign, magnitude and capped field sizes.
    always_comb begin
        neg_in   = !i_item.unsigned_mode && i_item.value_bits[VALUE_WIDTH-1];
        mag_in   = neg_in ? (~i_item.value_bits + 1'b1) : i_item.value_bits;
        width_in = CNT_W'(i_item.min_width);
        if (width_in > CNT_W'(MAX_FIELD)) width_in = CNT_W'(MAX_FIELD);
        prec_in  = CNT_W'(i_item.precision);
        if (prec_in > CNT_W'(MAX_FIELD)) prec_in = CNT_W'(MAX_FIELD);
        if (neg_in) begin
            sign_in = CH_MINUS;
        end else if (i_item.force_plus) begin
            sign_in = CH_PLUS;
        end else begin
            sign_in = CH_SPACE;
        end
    end

    // One shift-and-add-3 step per cycle builds the BCD digits; octal and hex
    // digits are plain slices of the magnitude.
    always_comb begin
        mag_ext = EXT_W'(r_mag);
        for (int k = 0; k < NUM_DIG; k++) begin
            adj[k]   = (r_digits[k] >= 4'd5) ? (r_digits[k] + 4'd3) : r_digits[k];
            oct_d[k] = {1'b0, mag_ext[3*k +: 3]};
            hex_d[k] = mag_ext[4*k +: 4];
        end
        dd_nxt[0] = {adj[0][2:0], r_mag[VALUE_WIDTH-1]};
        for (int k = 1; k < NUM_DIG; k++) begin
            dd_nxt[k] = {adj[k][2:0], adj[k-1][3]};
        end
    end

    // Significant digit count, at least one, then the digit limit.
    always_comb begin
        sig_cnt = ND_W'(1);
        for (int k = 0; k < NUM_DIG; k++) begin
            if (r_digits[k] != 4'd0) sig_cnt = ND_W'(k + 1);
        end
        nd_cap = (int'(sig_cnt) > DIGIT_LIMIT) ? ND_W'(DIGIT_LIMIT) : sig_cnt;
    end

    // Field layout.
    always_comb begin
        nd_ext   = CNT_W'(r_nd);
        sz_zeros = (r_prec > nd_ext) ? (r_prec - nd_ext) : '0;
        sz_body  = CNT_W'(r_has_sign) + sz_zeros + nd_ext;
        sz_pad   = (r_width > sz_body) ? (r_width - sz_body) : '0;
        // Zero padding only applies without a precision, and then replaces
        // the space padding on either side.
        if (r_zpad && (r_prec == '0)) begin
            sz_zeros = sz_zeros + sz_pad;
            sz_pad   = '0;
        end
        sz_total = sz_pad + CNT_W'(r_has_sign) + sz_zeros + nd_ext;
    end

    // Character selection in output order.
    always_comb begin
        dig_dec    = r_dig_left - ND_W'(1);
        dig_idx    = dig_dec[IDX_W-1:0];
        take_lead  = 1'b0;
        take_trail = 1'b0;
        if (!r_left && (r_pad_cnt != '0)) begin
            emit_ch   = CH_SPACE;
            take_lead = 1'b1;
        end else if (r_sign_pend) begin
            emit_ch = r_sign_ch;
        end else if (r_zero_cnt != '0) begin
            emit_ch = CH_ZERO;
        end else if (r_dig_left != '0) begin
            emit_ch = digit_char(r_digits[dig_idx], r_upper);
        end else begin
            emit_ch    = CH_SPACE;
            take_trail = 1'b1;
        end
        emit_last = (r_remain == CNT_W'(1)) || (r_emit_cnt == CNT_W'(MAX_OUT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag      <= mag_in;
            r_radix    <= i_item.radix_select;
            r_is_dec   <= (i_item.radix_select == RADIX_DEC);
            r_width    <= width_in;
            r_prec     <= prec_in;
            r_left     <= i_item.left_justify;
            r_zpad     <= i_item.zero_pad;
            r_upper    <= i_item.uppercase;
            r_has_sign <= !i_item.unsigned_mode &&
                          (neg_in || i_item.force_plus || i_item.space_sign);
            r_sign_ch  <= sign_in;
            r_bit_cnt  <= BIT_W'(VALUE_WIDTH - 1);
            for (int k = 0; k < NUM_DIG; k++) begin
                r_digits[k] <= 4'd0;
            end
        end else if (i_cmd.convert) begin
            if (r_is_dec) begin
                r_mag     <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt - 1'b1;
                for (int k = 0; k < NUM_DIG; k++) begin
                    r_digits[k] <= dd_nxt[k];
                end
            end else begin
                for (int k = 0; k < NUM_DIG; k++) begin
                    r_digits[k] <= (r_radix == RADIX_OCT) ? oct_d[k] : hex_d[k];
                end
            end
        end else if (i_cmd.measure) begin
            r_nd <= nd_cap;
        end else if (i_cmd.size) begin
            r_pad_cnt   <= sz_pad;
            r_zero_cnt  <= sz_zeros;
            r_dig_left  <= r_nd;
            r_sign_pend <= r_has_sign;
            r_remain    <= sz_total;
            r_emit_cnt  <= '0;
        end else if (i_cmd.emit) begin
            r_out.character <= emit_ch;
            r_out.last_char <= emit_last;
            r_remain        <= r_remain - 1'b1;
            r_emit_cnt      <= r_emit_cnt + 1'b1;
            if (take_lead || take_trail) begin
                r_pad_cnt <= r_pad_cnt - 1'b1;
            end else if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_zero_cnt != '0) begin
                r_zero_cnt <= r_zero_cnt - 1'b1;
            end else begin
                r_dig_left <= dig_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_status.conv_done = !r_is_dec || (r_bit_cnt == '0);
    assign o_status.emit_last = emit_last;
    assign o_result           = r_out;
    assign o_valid            = r_valid;

endmodule

FILE: rtl/integer_to_ascii_formatter_unit.sv
// Printf-style integer formatter: a transaction is accepted at a clock edge where start is high
// and busy is low, and the formatted text then comes out one ASCII character per cycle on
// o_result, each shown for exactly one cycle with o_valid high and the final one flagged by
// last_char; the receiver cannot stall, so it must take every character as it appears.
// A value of N characters (1 to 32) keeps busy high from its acceptance until its final
// character comes out; the controller goes through convert, measure, size and emit in that
// order, and in decimal the convert step is the BCD converter, which takes one value bit per
// cycle. The last character is on the port in the same cycle in which busy is already low again.
module integer_to_ascii_formatter_unit #(
    parameter int MAX_FIELD   = itaf_pkg::DEF_MAX_FIELD,
    parameter int DIGIT_LIMIT = itaf_pkg::DEF_DIGIT_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  itaf_pkg::t_fmt_in  i_item,
    output logic               busy,
    output logic               o_valid,
    output itaf_pkg::t_fmt_out o_result
);
    import itaf_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    itaf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    itaf_datapath #(
        .MAX_FIELD   (MAX_FIELD),
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

FILE: rtl/itaf_checker.sv
`include "integer_to_ascii_formatter_unit_defines.svh"

module itaf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input itaf_pkg::t_fmt_out o_result
);
    import itaf_pkg::*;

    // An accepted transaction keeps the block busy at least until its text starts.
    `ITAF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after acceptance")

    // Characters of one transaction come out back to back.
    `ITAF_ASSERT_NEXT(a_chars_contiguous, o_valid && !o_result.last_char, o_valid,
        "gap inside a character stream")

    // The final character is shown while the block is already free.
    `ITAF_ASSERT_NOW(a_last_idle, o_valid && o_result.last_char, !busy,
        "busy still high with the final character")

    // The block only goes idle by delivering a final character.
    `ITAF_ASSERT_NOW(a_fall_on_last, $fell(busy), o_valid && o_result.last_char,
        "busy fell without a final character")

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
